>>> sv/dtm_pkg.sv
package dtm_pkg;

  // Field widths of one request and one result
  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned REFRESH_W = 8;
  localparam int unsigned RATIO_W   = 4;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned COUNT_W   = 5;

  // Default table depth
  localparam int unsigned MAX_TIMINGS_DEF = 16;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_FIND  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_MOD,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                  func;
    logic [SLOT_W-1:0]     entry_index;
    logic [WIDTH_W-1:0]    width;
    logic [HEIGHT_W-1:0]   height;
    logic [REFRESH_W-1:0]  refresh;
    logic [RATIO_W-1:0]    ratio;
    logic                  interlaced;
    logic                  preferred;
    logic                  closest_multiple;
    logic                  fallback_default;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] match_index;
  } rsp_t;

  // One stored timing (46 bits)
  typedef struct packed {
    logic [WIDTH_W-1:0]   width;
    logic [HEIGHT_W-1:0]  height;
    logic [REFRESH_W-1:0] refresh;
    logic [RATIO_W-1:0]   ratio;
    logic                 interlaced;
    logic                 preferred;
  } entry_t;

  // Remainder unit control and status
  typedef struct packed {
    logic                 start;
    logic [REFRESH_W-1:0] dividend;
    logic [REFRESH_W-1:0] divisor;
  } rem_ctl_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_sts_t;

endpackage

>>> sv/dtm_stream_if.sv
interface dtm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> sv/dtm_rem_unit.sv
module dtm_rem_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtm_pkg::rem_ctl_t ctl_i,
  output dtm_pkg::rem_sts_t sts_o
);

  localparam int unsigned HW    = dtm_pkg::REFRESH_W;
  localparam int unsigned CNT_W = $clog2(HW);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [HW-1:0]    rem_q;
  logic [HW-1:0]    dvd_q;
  logic [HW-1:0]    dsr_q;
  logic [HW:0]      trial;
  logic [HW-1:0]    rem_d;

  // Shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    trial = {rem_q, dvd_q[HW-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = HW'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = HW'(trial);
    end
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(HW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= '0;
      dvd_q <= ctl_i.dividend;
      dsr_q <= ctl_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[HW-2:0], 1'b0};
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.zero = (rem_q == '0);

endmodule

>>> sv/display_timing_match_core.sv
// Timing table with first-match search. A write transfer stores one entry and
// gives no result. A find transfer gives one result after a scan that reads the
// table memory one entry at a time, up to the valid count, and stops on the
// first exact or preferred match. Each refresh-multiple candidate runs the shared
// bit-serial remainder unit (8 shift steps, then a done strobe). The input is not
// ready during a find; a finished result waits in the output register while writes
// still pass, and a stalled output register holds the next find in its final state.
// Configuration (valid entry count) is written through cfg_we_i / cfg_wdata_i.
module display_timing_match_core #(
  parameter int unsigned MAX_TIMINGS = dtm_pkg::MAX_TIMINGS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dtm_stream_if.sink                    req_i,
  dtm_stream_if.source                  rsp_o,
  input  logic                          cfg_we_i,
  input  logic [dtm_pkg::COUNT_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IW = (MAX_TIMINGS > 1) ? $clog2(MAX_TIMINGS) : 1;
  localparam int unsigned CW = $clog2(MAX_TIMINGS + 1);

  dtm_pkg::state_e                  state_q, state_d;
  logic [dtm_pkg::COUNT_W-1:0]      cfg_q;
  logic [CW-1:0]                    valid_n;
  logic [CW-1:0]                    idx_q, idx_d;
  logic                             have_q, have_d;
  logic                             have_pref_q, have_pref_d;
  logic [IW-1:0]                    sel_q, sel_d;
  logic [IW-1:0]                    first_pref_q, first_pref_d;
  logic [dtm_pkg::REFRESH_W-1:0]    sel_hz_q, sel_hz_d;
  dtm_pkg::req_t                    req_q, req_d;
  logic                             rsp_valid_q, rsp_valid_d;
  dtm_pkg::rsp_t                    rsp_q, rsp_d;
  dtm_pkg::entry_t                  mem_q [MAX_TIMINGS];
  dtm_pkg::entry_t                  rd_q;
  dtm_pkg::entry_t                  wr_entry;
  logic                             req_fire;
  logic [IW-1:0]                    cur;
  logic                             wild_all;
  logic                             geo;
  logic                             rate;
  logic                             pref_hit;
  logic                             cand;
  dtm_pkg::rem_ctl_t                rem_ctl;
  dtm_pkg::rem_sts_t                rem_sts;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == dtm_pkg::ST_IDLE);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  // Saturate the entry count at the table depth
  assign valid_n = (32'(cfg_q) > MAX_TIMINGS) ? CW'(MAX_TIMINGS) : CW'(cfg_q);

  // Table memory: one write port, one registered read port
  assign wr_entry.width      = req_i.data.width;
  assign wr_entry.height     = req_i.data.height;
  assign wr_entry.refresh    = req_i.data.refresh;
  assign wr_entry.ratio      = req_i.data.ratio;
  assign wr_entry.interlaced = req_i.data.interlaced;
  assign wr_entry.preferred  = req_i.data.preferred;

  always_ff @(posedge clk_i) begin
    if (req_fire && req_i.data.func == dtm_pkg::FUNC_WRITE &&
        32'(req_i.data.entry_index) < MAX_TIMINGS) begin
      mem_q[IW'(req_i.data.entry_index)] <= wr_entry;
    end
    rd_q <= mem_q[idx_q[IW-1:0]];
  end

  // Match terms for the entry under test
  assign cur      = idx_q[IW-1:0];
  assign wild_all = (req_q.width == '0) && (req_q.height == '0) && (req_q.refresh == '0);
  assign pref_hit = rd_q.preferred && (req_q.preferred || wild_all);
  assign geo      = ((req_q.width == '0) || (req_q.width == rd_q.width)) &&
                    ((req_q.height == '0) || (req_q.height == rd_q.height)) &&
                    ((req_q.ratio == '0) || (req_q.ratio == rd_q.ratio)) &&
                    (req_q.interlaced == rd_q.interlaced);
  assign rate     = (req_q.refresh == '0) || (req_q.refresh == rd_q.refresh);
  assign cand     = geo && req_q.closest_multiple && (req_q.refresh != '0) &&
                    (!have_q || (sel_hz_q > rd_q.refresh));

  dtm_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rem_ctl),
    .sts_o  (rem_sts)
  );

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    have_d       = have_q;
    have_pref_d  = have_pref_q;
    sel_d        = sel_q;
    first_pref_d = first_pref_q;
    sel_hz_d     = sel_hz_q;
    req_d        = req_q;
    rsp_d        = rsp_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rem_ctl.start    = 1'b0;
    rem_ctl.dividend = rd_q.refresh;
    rem_ctl.divisor  = req_q.refresh;

    unique case (state_q)
      dtm_pkg::ST_IDLE: begin
        if (req_i.valid && req_i.data.func == dtm_pkg::FUNC_FIND) begin
          req_d        = req_i.data;
          idx_d        = '0;
          have_d       = 1'b0;
          have_pref_d  = 1'b0;
          sel_d        = '0;
          first_pref_d = '0;
          sel_hz_d     = '0;
          state_d      = dtm_pkg::ST_READ;
        end
      end
      dtm_pkg::ST_READ: begin
        if (idx_q >= valid_n) begin
          state_d = dtm_pkg::ST_FINISH;
        end else begin
          state_d = dtm_pkg::ST_EVAL;
        end
      end
      dtm_pkg::ST_EVAL: begin
        if (rd_q.preferred && !have_pref_q) begin
          have_pref_d  = 1'b1;
          first_pref_d = cur;
        end
        if (pref_hit || (geo && rate)) begin
          have_d  = 1'b1;
          sel_d   = cur;
          state_d = dtm_pkg::ST_FINISH;
        end else if (cand) begin
          rem_ctl.start = 1'b1;
          state_d       = dtm_pkg::ST_MOD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = dtm_pkg::ST_READ;
        end
      end
      dtm_pkg::ST_MOD: begin
        if (rem_sts.done) begin
          if (rem_sts.zero) begin
            have_d   = 1'b1;
            sel_d    = cur;
            sel_hz_d = rd_q.refresh;
          end
          idx_d   = idx_q + 1'b1;
          state_d = dtm_pkg::ST_READ;
        end
      end
      dtm_pkg::ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_d.found = have_q || req_q.fallback_default;
          if (have_q) begin
            rsp_d.match_index = dtm_pkg::SLOT_W'(sel_q);
          end else if (req_q.fallback_default && have_pref_q) begin
            rsp_d.match_index = dtm_pkg::SLOT_W'(first_pref_q);
          end else begin
            rsp_d.match_index = '0;
          end
          state_d = dtm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dtm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtm_pkg::ST_IDLE;
      cfg_q       <= '0;
      rsp_valid_q <= 1'b0;
      have_q      <= 1'b0;
      have_pref_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      have_q      <= have_d;
      have_pref_q <= have_pref_d;
      idx_q       <= idx_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sel_q        <= sel_d;
    first_pref_q <= first_pref_d;
    sel_hz_q     <= sel_hz_d;
    req_q        <= req_d;
    rsp_q        <= rsp_d;
  end

`ifndef SYNTHESIS
  // An entry is only evaluated inside the valid range
  a_eval_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dtm_pkg::ST_EVAL |-> idx_q < valid_n)
    else $error("entry evaluated beyond the valid count");

  // A result without a match carries index zero
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_q.found |-> rsp_q.match_index == '0)
    else $error("no-match result with nonzero index");

  // The remainder unit reports done only while the sequencer waits for it
  a_rem_done_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_sts.done |-> state_q == dtm_pkg::ST_MOD)
    else $error("remainder done outside the multiple test");

  // A finished remainder test always advances the scan
  a_mod_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dtm_pkg::ST_MOD && rem_sts.done |=>
      state_q == dtm_pkg::ST_READ && idx_q == $past(idx_q) + 1'b1)
    else $error("scan did not advance after the remainder test");
`endif

endmodule

>>> tb/display_timing_match_checker.sv
module display_timing_match_checker #(
  parameter int unsigned DEPTH = dtm_pkg::MAX_TIMINGS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  dtm_pkg::req_t               req_data_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  dtm_pkg::rsp_t               rsp_data_i,
  input  logic                        cfg_we_i,
  input  logic [dtm_pkg::COUNT_W-1:0] cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          hit_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  dtm_pkg::entry_t             timing_tbl [DEPTH];
  logic [dtm_pkg::COUNT_W-1:0] slot_count;
  dtm_pkg::rsp_t               match_q [$];

  // Pick the entry a search should land on, given the current table
  function automatic dtm_pkg::rsp_t predict_match(dtm_pkg::req_t q);
    dtm_pkg::rsp_t   res;
    dtm_pkg::entry_t e;
    int unsigned     n;
    int unsigned     pick;
    int unsigned     first_pref;
    bit              hit;
    bit              seen_pref;
    bit              stop;
    bit              geo_ok;
    bit              rate_ok;
    n          = (slot_count > DEPTH) ? DEPTH : slot_count;
    pick       = 0;
    first_pref = 0;
    hit        = 1'b0;
    seen_pref  = 1'b0;
    stop       = 1'b0;
    for (int unsigned i = 0; i < n && !stop; i++) begin
      e = timing_tbl[i];
      // A preferred entry ends a preferred or all-wildcard search
      if (e.preferred) begin
        if (!seen_pref) begin
          seen_pref  = 1'b1;
          first_pref = i;
        end
        if (q.preferred || (q.width == '0 && q.height == '0 && q.refresh == '0)) begin
          hit  = 1'b1;
          pick = i;
          stop = 1'b1;
        end
      end
      if (!stop) begin
        geo_ok  = (q.width == '0 || q.width == e.width) &&
                  (q.height == '0 || q.height == e.height) &&
                  (q.ratio == '0 || q.ratio == e.ratio) &&
                  (q.interlaced == e.interlaced);
        rate_ok = (q.refresh == '0 || q.refresh == e.refresh);
        if (geo_ok && rate_ok) begin
          hit  = 1'b1;
          pick = i;
          stop = 1'b1;
        end else if (geo_ok && q.closest_multiple && q.refresh != '0 &&
                     (!hit || timing_tbl[pick].refresh > e.refresh) &&
                     (e.refresh % q.refresh) == '0) begin
          // Hold the lowest-rate multiple seen so far
          hit  = 1'b1;
          pick = i;
        end
      end
    end
    if (!hit && q.fallback_default) begin
      hit  = 1'b1;
      pick = seen_pref ? first_pref : 0;
    end
    res.found       = hit;
    res.match_index = hit ? dtm_pkg::SLOT_W'(pick) : '0;
    return res;
  endfunction

  // Track table and count, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    dtm_pkg::rsp_t got;
    dtm_pkg::rsp_t want;
    if (!rst_ni) begin
      match_q.delete();
      slot_count   = '0;
      fail_count_o = 0;
      pending_o    = 0;
      hit_count_o  = 0;
      for (int i = 0; i < DEPTH; i++) timing_tbl[i] = '0;
    end else begin
      if (cfg_we_i) begin
        slot_count = cfg_wdata_i;
      end
      // Result transfer: match against the oldest prediction
      if (rsp_valid_i && rsp_ready_i) begin
        got = rsp_data_i;
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result found=%0b index=%0d, none expected",
                   $time, got.found, got.match_index);
          fail_count_o++;
        end else begin
          want = match_q.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, got %0b",
                     $time, want.found, got.found);
            fail_count_o++;
          end
          if (got.match_index !== want.match_index) begin
            $display("%0t: match_index mismatch: expected %0d, got %0d",
                     $time, want.match_index, got.match_index);
            fail_count_o++;
          end
          if (want.found) hit_count_o++;
        end
      end
      // Request transfer: store an entry or predict a search
      if (req_valid_i && req_ready_i) begin
        if (req_data_i.func == dtm_pkg::FUNC_WRITE) begin
          if (req_data_i.entry_index < DEPTH) begin
            timing_tbl[req_data_i.entry_index] = {req_data_i.width, req_data_i.height,
                                                  req_data_i.refresh, req_data_i.ratio,
                                                  req_data_i.interlaced,
                                                  req_data_i.preferred};
          end
        end else begin
          match_q.push_back(predict_match(req_data_i));
        end
      end
      pending_o = match_q.size();
    end
  end

endmodule

>>> tb/display_timing_match_core_tb.sv
module display_timing_match_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS   = 98;
  localparam int unsigned NUM_PHASES    = 12;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [dtm_pkg::COUNT_W-1:0] cfg_wdata;

  dtm_stream_if #(.payload_t(dtm_pkg::req_t)) req_if ();
  dtm_stream_if #(.payload_t(dtm_pkg::rsp_t)) rsp_if ();

  int              fail_count;
  int              pending;
  int              hit_count;
  int unsigned     send_idle_pct = 0;
  int unsigned     rsp_stall_pct = 0;
  int unsigned     quiet_cycles  = 0;
  int unsigned     writes_sent   = 0;
  int unsigned     finds_sent    = 0;
  dtm_pkg::entry_t shadow_tbl [dtm_pkg::MAX_TIMINGS_DEF];
  int unsigned     phase_counts [NUM_PHASES] = '{16, 31, 3, 0, 8, 17, 1, 12, 16, 5, 20, 16};

  display_timing_match_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  display_timing_match_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_data_i   (req_if.data),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_data_i   (rsp_if.data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .hit_count_o  (hit_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("display_timing_match_core verification failed");
      $finish;
    end
  end

  // Offer one request and hold it until the transfer; valid stays high on return
  task automatic push_req(input dtm_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    if (r.func == dtm_pkg::FUNC_WRITE) begin
      shadow_tbl[r.entry_index] = {r.width, r.height, r.refresh, r.ratio,
                                   r.interlaced, r.preferred};
      writes_sent++;
    end else begin
      finds_sent++;
    end
  endtask

  // Drop valid and wait for every pending search to return
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_valid_count(input int unsigned n);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= dtm_pkg::COUNT_W'(n);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_write(input int unsigned idx, input int unsigned w, input int unsigned h,
                            input int unsigned hz, input int unsigned ar, input bit il,
                            input bit pref);
    dtm_pkg::req_t r;
    r             = '0;
    r.func        = dtm_pkg::FUNC_WRITE;
    r.entry_index = dtm_pkg::SLOT_W'(idx);
    r.width       = dtm_pkg::WIDTH_W'(w);
    r.height      = dtm_pkg::HEIGHT_W'(h);
    r.refresh     = dtm_pkg::REFRESH_W'(hz);
    r.ratio       = dtm_pkg::RATIO_W'(ar);
    r.interlaced  = il;
    r.preferred   = pref;
    push_req(r);
  endtask

  task automatic send_find(input int unsigned w, input int unsigned h, input int unsigned hz,
                           input int unsigned ar, input bit il, input bit pref, input bit cm,
                           input bit fb);
    dtm_pkg::req_t r;
    r                  = '0;
    r.func             = dtm_pkg::FUNC_FIND;
    r.width            = dtm_pkg::WIDTH_W'(w);
    r.height           = dtm_pkg::HEIGHT_W'(h);
    r.refresh          = dtm_pkg::REFRESH_W'(hz);
    r.ratio            = dtm_pkg::RATIO_W'(ar);
    r.interlaced       = il;
    r.preferred        = pref;
    r.closest_multiple = cm;
    r.fallback_default = fb;
    push_req(r);
  endtask

  // Entry write, mostly common modes so that searches land on them
  function automatic dtm_pkg::req_t random_write();
    dtm_pkg::req_t r;
    logic [63:0]   noise;
    noise  = {$urandom, $urandom};
    r      = noise[$bits(dtm_pkg::req_t)-1:0];
    r.func = dtm_pkg::FUNC_WRITE;
    if ($urandom_range(99) < 75) begin
      case ($urandom_range(3))
        0: begin r.width = 16'd640;  r.height = 16'd480;  end
        1: begin r.width = 16'd1280; r.height = 16'd720;  end
        2: begin r.width = 16'd1920; r.height = 16'd1080; end
        default: begin r.width = 16'd3840; r.height = 16'd2160; end
      endcase
      case ($urandom_range(5))
        0: r.refresh = 8'd24;
        1: r.refresh = 8'd30;
        2: r.refresh = 8'd60;
        3: r.refresh = 8'd90;
        4: r.refresh = 8'd120;
        default: r.refresh = 8'd240;
      endcase
      r.ratio      = dtm_pkg::RATIO_W'($urandom_range(3));
      r.interlaced = ($urandom_range(4) == 0);
    end
    r.preferred = ($urandom_range(99) < 15);
    return r;
  endfunction

  // Search built from a stored entry with wildcards and rate divisors, or pure noise
  function automatic dtm_pkg::req_t random_find();
    dtm_pkg::req_t   r;
    dtm_pkg::entry_t e;
    logic [63:0]     noise;
    noise  = {$urandom, $urandom};
    r      = noise[$bits(dtm_pkg::req_t)-1:0];
    r.func = dtm_pkg::FUNC_FIND;
    if ($urandom_range(99) < 80) begin
      e                  = shadow_tbl[$urandom_range(dtm_pkg::MAX_TIMINGS_DEF - 1)];
      r.width            = ($urandom_range(4) == 0) ? '0 : e.width;
      r.height           = ($urandom_range(4) == 0) ? '0 : e.height;
      r.ratio            = ($urandom_range(2) == 0) ? '0 : e.ratio;
      r.interlaced       = ($urandom_range(9) == 0) ? !e.interlaced : e.interlaced;
      r.preferred        = ($urandom_range(9) == 0);
      r.closest_multiple = ($urandom_range(1) == 0);
      case ($urandom_range(3))
        0: r.refresh = '0;
        1: r.refresh = e.refresh;
        default: r.refresh = e.refresh / dtm_pkg::REFRESH_W'($urandom_range(5, 2));
      endcase
    end
    return r;
  endfunction

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty table: no match, then fallback to slot zero
    send_find(1920, 1080, 60, 2, 1'b0, 1'b0, 1'b0, 1'b0);
    send_find(1920, 1080, 60, 2, 1'b0, 1'b0, 1'b0, 1'b1);

    // Fill every slot before any of them becomes valid
    send_write(0,  640,   480,   60,  1,  1'b0, 1'b0);
    send_write(1,  1920,  1080,  120, 2,  1'b0, 1'b0);
    send_write(2,  1920,  1080,  60,  2,  1'b1, 1'b0);
    send_write(3,  1920,  1080,  90,  2,  1'b0, 1'b0);
    send_write(4,  1280,  720,   60,  2,  1'b0, 1'b1);
    send_write(5,  1920,  1080,  240, 2,  1'b0, 1'b0);
    send_write(6,  1920,  1080,  30,  2,  1'b0, 1'b0);
    send_write(7,  3840,  2160,  60,  2,  1'b0, 1'b1);
    send_write(8,  65535, 65535, 255, 15, 1'b1, 1'b1);
    send_write(9,  0,     0,     0,   0,  1'b0, 1'b0);
    send_write(10, 1920,  1080,  50,  3,  1'b0, 1'b0);
    send_write(11, 800,   600,   75,  1,  1'b0, 1'b0);
    send_write(12, 1024,  768,   60,  1,  1'b0, 1'b0);
    send_write(13, 1920,  1080,  60,  2,  1'b0, 1'b1);
    send_write(14, 720,   576,   50,  4,  1'b1, 1'b0);
    send_write(15, 1280,  1024,  75,  1,  1'b0, 1'b0);
    set_valid_count(16);

    // Exact, multiple-rate, wildcard, preferred, fallback and extreme searches
    send_find(1920,  1080,  60,  2,  1'b1, 1'b0, 1'b0, 1'b0);
    send_find(1920,  1080,  30,  0,  1'b0, 1'b0, 1'b1, 1'b0);
    send_find(1920,  1080,  45,  0,  1'b0, 1'b0, 1'b1, 1'b0);
    send_find(1920,  1080,  0,   0,  1'b0, 1'b0, 1'b1, 1'b0);
    send_find(640,   480,   60,  1,  1'b0, 1'b1, 1'b0, 1'b0);
    send_find(0,     0,     0,   0,  1'b1, 1'b0, 1'b0, 1'b0);
    send_find(12345, 1080,  60,  2,  1'b0, 1'b0, 1'b1, 1'b0);
    send_find(12345, 1080,  60,  2,  1'b0, 1'b0, 1'b0, 1'b1);
    send_find(65535, 65535, 255, 15, 1'b1, 1'b0, 1'b0, 1'b0);
    send_find(640,   480,   60,  1,  1'b1, 1'b0, 1'b1, 1'b0);

    // Random phases across table sizes and flow-control mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_valid_count(phase_counts[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 61; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 61; end
        default: begin send_idle_pct = 17; rsp_stall_pct = 17; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 45) push_req(random_write());
        else push_req(random_find());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d entry writes and %0d searches (%0d landing on an entry)",
             writes_sent, finds_sent, hit_count);
    $display("over %0d valid-count settings with idle and stall mixes on both channels.",
             NUM_PHASES + 1);
    if (fail_count == 0 && pending == 0) begin
      $display("display_timing_match_core verification clean");
    end else begin
      $display("display_timing_match_core verification failed");
    end
    $finish;
  end

endmodule
